### src/tpra_pkg.sv
// Shared types and constants for the touch pair report assembler.
// No dependencies; imported by every module of the block.
package tpra_pkg;

   localparam logic KIND_CONTACT = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   localparam int unsigned STATUS_VALID_BIT = 7;
   localparam int unsigned STATUS_ID_LSB    = 2;
   localparam int unsigned ID_W             = 5;
   localparam int unsigned COORD_W          = 16;

   typedef struct packed {
      logic       pen_level_down;
      logic       read_ok;
      logic [7:0] status_byte;
      logic [7:0] x_low;
      logic [7:0] x_high;
      logic [7:0] y_low;
      logic [7:0] y_high;
   } item_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic               updown;
      logic               valid;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } slot_type;

   typedef struct packed {
      logic                      report_kind;
      logic [ID_W-1:0]           tracking_id;
      logic                      touch_major;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic                      frame_sync;
      logic                      last;
   } report_type;

   function automatic slot_type decode_slot(input item_type item);
      slot_type s;
      s.updown = item.status_byte[0];
      s.valid  = item.status_byte[STATUS_VALID_BIT];
      s.id     = item.status_byte[STATUS_ID_LSB +: ID_W];
      s.x      = {item.x_high, item.x_low};
      s.y      = {item.y_high, item.y_low};
      return s;
   endfunction

endpackage

### src/touch_pair_report_assembler.sv
// A poll is registered on transfer, then processed into the result register once that
// register is empty or its last held report leaves. Throughput: one poll per cycle
// when it yields at most one report and rsp_tready is high; a poll that yields two
// holds the next one back, as the output port passes one report per transfer.
// Reset (synchronous, active high) empties both registers and clears pen/pair state.
module touch_pair_report_assembler
   import tpra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // status_byte, x_low, x_high, y_low, y_high
   input  logic [1:0]  req_tuser,  // pen_level_down, read_ok
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // tracking_id, touch_major, pos_x, pos_y, zero pad
   output logic [1:0]  rsp_tuser,  // report_kind, frame_sync
   output logic        rsp_tlast
);

   item_type   item_ff, item_in;
   logic       item_valid_ff;
   logic       can_load, advance;
   logic [1:0] rep_count;
   report_type rep0, rep1, rsp_rep;

   assign item_in = '{pen_level_down: req_tuser[0], read_ok: req_tuser[1],
                      status_byte: req_tdata[7:0], x_low: req_tdata[15:8],
                      x_high: req_tdata[23:16], y_low: req_tdata[31:24],
                      y_high: req_tdata[39:32]};

   assign advance    = item_valid_ff && can_load;
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   tpra_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item      (item_ff),
      .advance   (advance),
      .rep0      (rep0),
      .rep1      (rep1),
      .rep_count (rep_count)
   );

   tpra_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .rep0       (rep0),
      .rep1       (rep1),
      .rep_count  (rep_count),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_rep    (rsp_rep)
   );

   assign rsp_tdata = {2'b00, rsp_rep.pos_y, rsp_rep.pos_x, rsp_rep.touch_major,
                       rsp_rep.tracking_id};
   assign rsp_tuser = {rsp_rep.frame_sync, rsp_rep.report_kind};
   assign rsp_tlast = rsp_rep.last;

endmodule

### src/tpra_core.sv
// Slot and pen state, pair assembly and report generation for one poll.
// Depends on tpra_pkg.
module tpra_core
   import tpra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       advance,
   output report_type rep0,
   output report_type rep1,
   output logic [1:0] rep_count
);

   // Only slot 0 needs storing: slot 1 is reported in the poll that writes it.
   slot_type slot0_ff, slot0_in;
   logic     filled_ff, filled_in;
   logic     pen_ff, pen_in;

   slot_type   dec;
   logic       dup, emit_a, emit_b, sync_a;
   report_type rep_a, rep_b, rep_rel;

   always_comb begin
      dec    = decode_slot(item);
      dup    = (slot0_ff.id == dec.id) && (slot0_ff.updown == dec.updown) &&
               (slot0_ff.x == dec.x) && (slot0_ff.y == dec.y);
      sync_a = !((slot0_ff.id != dec.id) && dec.valid);

      rep_a = '{report_kind: KIND_CONTACT, tracking_id: slot0_ff.id, touch_major: 1'b1,
                pos_x: slot0_ff.x, pos_y: slot0_ff.y, frame_sync: sync_a, last: 1'b0};
      rep_b = '{report_kind: KIND_CONTACT, tracking_id: dec.id, touch_major: 1'b1,
                pos_x: dec.x, pos_y: dec.y, frame_sync: 1'b1, last: 1'b1};
      rep_rel = '{report_kind: KIND_RELEASE, tracking_id: '0, touch_major: 1'b0,
                  pos_x: '0, pos_y: '0, frame_sync: 1'b1, last: 1'b1};

      slot0_in  = slot0_ff;
      filled_in = filled_ff;
      pen_in    = pen_ff;
      rep0      = rep_b;
      rep1      = rep_b;
      rep_count = 2'd0;
      emit_a    = 1'b0;
      emit_b    = 1'b0;

      if (item.pen_level_down) begin
         if (item.read_ok) begin
            pen_in = 1'b1;
            if (!filled_ff) begin
               slot0_in  = dec;
               filled_in = 1'b1;
            end else begin
               filled_in = 1'b0;
               emit_a    = !dup && slot0_ff.valid;
               emit_b    = dec.valid;
               if (emit_a && emit_b) begin
                  rep0      = rep_a;
                  rep_count = 2'd2;
               end else if (emit_a) begin
                  rep0      = rep_a;
                  rep0.last = 1'b1;
                  rep_count = 2'd1;
               end else if (emit_b) begin
                  rep_count = 2'd1;
               end
            end
         end
      end else begin
         filled_in = 1'b0;
         if (pen_ff) begin
            pen_in    = 1'b0;
            rep0      = rep_rel;
            rep_count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= 1'b0;
         pen_ff    <= 1'b0;
      end else if (advance) begin
         filled_ff <= filled_in;
         pen_ff    <= pen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot0_ff <= slot0_in;
      end
   end

endmodule

### src/tpra_rsp_buf.sv
// Two-entry result register draining one report per transfer.
// Depends on tpra_pkg.
module tpra_rsp_buf
   import tpra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  report_type rep0,
   input  report_type rep1,
   input  logic [1:0] rep_count,
   output logic       can_load,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output report_type rsp_rep
);

   report_type e0_ff, e1_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_rep    = e0_ff;
   assign pop        = rsp_tvalid && rsp_tready;
   // empty, or the last held report leaves this cycle
   assign can_load   = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (load) begin
         count_ff <= rep_count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         e0_ff <= rep0;
         e1_ff <= rep1;
      end else if (pop) begin
         e0_ff <= e1_ff;
      end
   end

endmodule

### src/tpra_checker.sv
// Port-level checks for touch_pair_report_assembler, attached by bind.
// Depends on tpra_pkg for the report kind codes.
module tpra_checker
   import tpra_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // release report carries no position, ends the poll and syncs
   a_release_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == KIND_RELEASE) |->
      (rsp_tdata == 40'd0) && rsp_tlast && rsp_tuser[1])
      else $error("malformed release report");

   // contact report always has touch_major set
   a_contact_major: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == KIND_CONTACT) |-> rsp_tdata[5])
      else $error("contact report without touch_major");

   // only the first of a pair is not last, and it is a contact report
   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tuser[0] == KIND_CONTACT))
      else $error("non-final release report");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result presented straight after reset");

endmodule

bind touch_pair_report_assembler tpra_checker u_tpra_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### dv/touch_report_checker.sv
`timescale 1ns / 100ps
// Checker for the touch pair report assembler: watches both stream channels,
// predicts the reports each poll causes and compares them. Uses tpra_pkg.
module touch_report_checker
   import tpra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,  // status_byte, x_low, x_high, y_low, y_high
   input  logic [1:0]  req_tuser,  // pen_level_down, read_ok
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,  // tracking_id, touch_major, pos_x, pos_y, zero pad
   input  logic [1:0]  rsp_tuser,  // report_kind, frame_sync
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          reports_pending
);

   slot_type   slots [2];
   logic [1:0] slots_used;
   logic       pen_held;
   report_type pending_reports [$];
   int         failures = 0;
   int         outstanding = 0;

   assign fail_count      = failures;
   assign reports_pending = outstanding;

   task automatic clear_slots();
      foreach (slots[k]) begin
         slots[k]        = '0;
         slots[k].updown = 1'b1;
      end
   endtask

   function automatic report_type contact_report(input slot_type s, input logic sync);
      report_type r;
      r             = '0;
      r.report_kind = KIND_CONTACT;
      r.tracking_id = s.id;
      r.touch_major = 1'b1;
      r.pos_x       = s.x;
      r.pos_y       = s.y;
      r.frame_sync  = sync;
      return r;
   endfunction

   // works out the reports one accepted poll causes and queues them
   task automatic assemble_reports(input item_type p);
      slot_type   pt;
      report_type batch [2];
      int         n;
      logic       same;
      n = 0;
      if (p.pen_level_down) begin
         if (p.read_ok) begin
            pt.updown = p.status_byte[0];
            pt.valid  = p.status_byte[STATUS_VALID_BIT];
            pt.id     = p.status_byte[STATUS_ID_LSB +: ID_W];
            pt.x      = {p.x_high, p.x_low};
            pt.y      = {p.y_high, p.y_low};
            if (slots_used > 2'd1) slots[0] = pt;
            else slots[slots_used[0]] = pt;
            slots_used = slots_used + 2'd1;
            pen_held   = 1'b1;
            if (slots_used == 2'd2) begin
               // valid takes no part in the duplicate test
               same = slots[0].id == slots[1].id && slots[0].updown == slots[1].updown &&
                      slots[0].x == slots[1].x && slots[0].y == slots[1].y;
               if (!same && slots[0].valid) begin
                  batch[n] = contact_report(slots[0],
                     !(slots[0].id != slots[1].id && slots[1].valid));
                  n++;
               end
               if (slots[1].valid) begin
                  batch[n] = contact_report(slots[1], 1'b1);
                  n++;
               end
               slots_used = 2'd0;
            end
         end
      end else begin
         if (pen_held) begin
            pen_held               = 1'b0;
            batch[n]               = '0;
            batch[n].report_kind   = KIND_RELEASE;
            batch[n].frame_sync    = 1'b1;
            n++;
            clear_slots();
         end
         slots_used = 2'd0;
      end
      for (int k = 0; k < n; k++) begin
         batch[k].last = (k == n - 1);
         pending_reports.push_back(batch[k]);
      end
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic check_report();
      report_type want;
      if (pending_reports.size() == 0) begin
         $display("%0t: unexpected report transfer, expected none, got tdata %h tuser %b tlast %b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
         failures++;
      end else begin
         want = pending_reports.pop_front();
         check_field("report_kind", want.report_kind, rsp_tuser[0]);
         check_field("tracking_id", want.tracking_id, rsp_tdata[4:0]);
         check_field("touch_major", want.touch_major, rsp_tdata[5]);
         check_field("pos_x", want.pos_x, $signed(rsp_tdata[21:6]));
         check_field("pos_y", want.pos_y, $signed(rsp_tdata[37:22]));
         check_field("frame_sync", want.frame_sync, rsp_tuser[1]);
         check_field("last", want.last, rsp_tlast);
         check_field("tdata pad", 0, rsp_tdata[39:38]);
      end
   endtask

   always @(posedge clock) begin
      item_type p;
      if (reset) begin
         clear_slots();
         slots_used = 2'd0;
         pen_held   = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            p.pen_level_down = req_tuser[0];
            p.read_ok        = req_tuser[1];
            p.status_byte    = req_tdata[7:0];
            p.x_low          = req_tdata[15:8];
            p.x_high         = req_tdata[23:16];
            p.y_low          = req_tdata[31:24];
            p.y_high         = req_tdata[39:32];
            assemble_reports(p);
         end
         if (rsp_tvalid && rsp_tready) check_report();
      end
      outstanding = pending_reports.size();
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Top of the touch pair report assembler testbench: clock, reset, poll stimulus
// and report back-pressure. Needs tpra_pkg, the block and touch_report_checker.
module testbench;
   import tpra_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;  // status_byte, x_low, x_high, y_low, y_high
   logic [1:0]  req_tuser;  // pen_level_down, read_ok
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;  // tracking_id, touch_major, pos_x, pos_y, zero pad
   logic [1:0]  rsp_tuser;  // report_kind, frame_sync
   logic        rsp_tlast;
   int          fail_count;
   int          reports_pending;

   bit calm       = 1'b0;
   bit hold_rsp   = 1'b0;
   int polls_sent = 0;

   touch_pair_report_assembler u_top (.*);
   touch_report_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("touch_pair_report_assembler: mismatch");
      $finish;
   end

   // mostly short gaps, now and then a long one; none in calm stretches
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] make_status(input logic valid, input logic [4:0] id,
                                              input logic updown);
      return {valid, id, 1'($urandom), updown};
   endfunction

   function automatic item_type make_poll(input logic pen, input logic ok,
                                          input logic [7:0] status,
                                          input logic [15:0] x, input logic [15:0] y);
      item_type p;
      p.pen_level_down = pen;
      p.read_ok        = ok;
      p.status_byte    = status;
      p.x_low          = x[7:0];
      p.x_high         = x[15:8];
      p.y_low          = y[7:0];
      p.y_high         = y[15:8];
      return p;
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 15))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h8000;
         3: return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   // few ids in play so that pairs often share one
   function automatic logic [4:0] pick_id();
      if ($urandom_range(0, 99) < 60) return 5'($urandom_range(0, 3));
      return 5'($urandom);
   endfunction

   function automatic item_type noise_poll();
      return make_poll(1'($urandom), 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   task automatic send_poll(input item_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {p.y_high, p.y_low, p.x_high, p.x_low, p.status_byte};
      req_tuser  <= {p.read_ok, p.pen_level_down};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      polls_sent++;
   endtask

   // a touch: pairs of good reads, a stray bus failure now and then, then the lift
   task automatic touch_episode();
      int       pairs;
      item_type first;
      item_type second;
      pairs = $urandom_range(1, 6);
      for (int k = 0; k < pairs; k++) begin
         first = make_poll(1'b1, 1'b1,
                           make_status($urandom_range(0, 99) < 85, pick_id(), 1'($urandom)),
                           rand_coord(), rand_coord());
         send_poll(first);
         if ($urandom_range(0, 9) == 0) send_poll(make_poll(1'b1, 1'b0, 8'($urandom),
                                                  16'($urandom), 16'($urandom)));
         if ($urandom_range(0, 11) == 0) break;  // lift with one slot filled
         case ($urandom_range(0, 3))
            0: begin
               second = first;
               second.status_byte[STATUS_VALID_BIT] = 1'($urandom);
               if ($urandom_range(0, 3) == 0) second.status_byte[0] = ~first.status_byte[0];
            end
            1: second = make_poll(1'b1, 1'b1,
                                  make_status($urandom_range(0, 99) < 85,
                                              first.status_byte[STATUS_ID_LSB +: ID_W],
                                              1'($urandom)),
                                  rand_coord(), rand_coord());
            default: second = make_poll(1'b1, 1'b1,
                                        make_status($urandom_range(0, 99) < 85, pick_id(),
                                                    1'($urandom)),
                                        rand_coord(), rand_coord());
         endcase
         send_poll(second);
      end
      send_poll(make_poll(1'b0, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)));
   endtask

   // report side back-pressure
   initial begin
      int len;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            len      = 400;
            hold_rsp = 1'b0;
         end else if (calm || $urandom_range(0, 99) < 60) begin
            rsp_tready <= 1'b1;
            len = $urandom_range(1, 16);
         end else begin
            rsp_tready <= 1'b0;
            len = pick_gap();
            if (len == 0) len = 1;
         end
         repeat (len - 1) @(negedge clock);
      end
   end

   initial begin
      bit pressed;
      pressed    = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lift with no touch, bus failure, lift again: all silent
      send_poll(make_poll(1'b0, 1'b1, 8'hff, 16'hffff, 16'hffff));
      send_poll(make_poll(1'b1, 1'b0, 8'hff, 16'hffff, 16'hffff));
      send_poll(make_poll(1'b0, 1'b0, 8'h00, 16'h0000, 16'h0000));
      // two distinct valid fingers, extremes of id and position
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b1, 5'd0, 1'b0), 16'h0000, 16'h0000));
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b1, 5'd31, 1'b1), 16'hffff, 16'hffff));
      // same id, new position
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b1, 5'd7, 1'b1), 16'h1234, 16'h5678));
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b1, 5'd7, 1'b1), 16'h1235, 16'h5678));
      // duplicate, first slot invalid
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b0, 5'd9, 1'b0), 16'h0100, 16'h0200));
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b1, 5'd9, 1'b0), 16'h0100, 16'h0200));
      // duplicate, both valid
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b1, 5'd12, 1'b1), 16'h8000, 16'h7fff));
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b1, 5'd12, 1'b1), 16'h8000, 16'h7fff));
      // second slot invalid, so the first carries the sync
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b1, 5'd3, 1'b0), 16'h00ff, 16'hff00));
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b0, 5'd4, 1'b0), 16'hff00, 16'h00ff));
      // neither valid
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b0, 5'd1, 1'b1), 16'h0001, 16'h0001));
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b0, 5'd2, 1'b0), 16'h0002, 16'h0002));
      // half pair, bus failure, lift: release report and slot count back to zero
      send_poll(make_poll(1'b1, 1'b1, make_status(1'b1, 5'd5, 1'b0), 16'h0aaa, 16'h0555));
      send_poll(make_poll(1'b1, 1'b0, 8'hff, 16'hffff, 16'hffff));
      send_poll(make_poll(1'b0, 1'b1, 8'hff, 16'hffff, 16'hffff));
      send_poll(make_poll(1'b0, 1'b1, 8'hff, 16'hffff, 16'hffff));
      send_poll(make_poll(1'b1, 1'b1, 8'hff, 16'h8000, 16'h7fff));
      send_poll(make_poll(1'b1, 1'b1, 8'h00, 16'h7fff, 16'h8000));
      send_poll(make_poll(1'b0, 1'b0, 8'h00, 16'h0000, 16'h0000));

      hold_rsp = 1'b1;
      while (polls_sent < 1925) begin
         if ($urandom_range(0, 9) == 0) calm = ~calm;
         if (!pressed && polls_sent > 1000) begin
            hold_rsp = 1'b1;
            pressed  = 1'b1;
         end
         if ($urandom_range(0, 99) < 80) touch_episode();
         else repeat ($urandom_range(1, 6)) send_poll(noise_poll());
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (reports_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0) $display("touch_pair_report_assembler: match");
      else $display("touch_pair_report_assembler: mismatch");
      $finish;
   end

endmodule

### touch_pair_report_assembler.f
src/tpra_pkg.sv
src/tpra_core.sv
src/tpra_rsp_buf.sv
src/touch_pair_report_assembler.sv
src/tpra_checker.sv
dv/touch_report_checker.sv
dv/testbench.sv
